// ----- hdl/cmm_pkg.sv -----
// Shared types, constants and the cosine table generator for the cyclic motor mixer.
// Used by cmm_lane and cyclic_modulated_motor_mixer; no dependencies of its own.
package cmm_pkg;

  localparam int unsigned MOTOR_COUNT         = 3;
  localparam int unsigned COS_TABLE_BITS_DEF  = 10;

  // Q1.14 thresholds
  localparam logic [14:0] Q14_ONE     = 15'd16384;
  localparam logic [14:0] HIGH_THRESH = 15'd16368;
  localparam logic [14:0] LOW_THRESH  = 15'd16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_COLLECTIVE_GAIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_LIMIT    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_PHASE      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_PHASE     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_BIAS        = 4'd7;

  // Configuration reset values
  localparam logic [15:0] RST_COLLECTIVE_GAIN = 16'd16384;
  localparam logic [14:0] RST_ROLL_GAIN       = 15'd1638;
  localparam logic [14:0] RST_PITCH_GAIN      = 15'd1638;
  localparam logic [14:0] RST_YAW_GAIN        = 15'd819;
  localparam logic [13:0] RST_CYCLIC_LIMIT    = 14'd3277;
  localparam logic [47:0] RST_ROLL_PHASE      = 48'd187652847763456;
  localparam logic [47:0] RST_PITCH_PHASE     = 48'd164196241850368;
  localparam logic [47:0] RST_YAW_BIAS        = 48'd246294362734592;

  // Spool modes; the unused code mixes like active
  localparam logic [1:0] SPOOL_SHUTDOWN = 2'd0;
  localparam logic [1:0] SPOOL_GROUND   = 2'd1;
  localparam logic [1:0] SPOOL_ACTIVE   = 2'd2;

  // Lane sequence steps
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_ROLL_GAIN  = 4'd1,
    OP_ROLL_COS   = 4'd2,
    OP_PITCH_GAIN = 4'd3,
    OP_PITCH_COS  = 4'd4,
    OP_YAW_GAIN   = 4'd5,
    OP_YAW_BIAS   = 4'd6,
    OP_YAW_ACC    = 4'd7,
    OP_ROUND      = 4'd8,
    OP_CLAMP      = 4'd9
  } cmm_op_e;

  typedef struct packed {
    logic    en;
    cmm_op_e op;
  } cmm_lane_ctrl_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } cmm_lane_stat_t;

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  // Quarter-wave cosine magnitude in Q1.14 for table entry k; evaluated at
  // elaboration only (Horner form of the Taylor series to x^12 in Q30).
  function automatic logic [14:0] cmm_cos_entry(input int unsigned k,
                                                input int unsigned bits);
    longint r;
    longint x;
    longint x2;
    longint t;
    longint v;
    r  = longint'(k) << (16 - bits);
    x  = (r * TWO_PI_Q30) >>> 16;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 132;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 90;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 56;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 30;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 12;
    t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 2;
    if (t < 0) t = 0;
    v = (t + 32768) >>> 16;
    if (v > 16384) v = 16384;
    return 15'(v);
  endfunction

endpackage

// ----- hdl/cmm_lane.sv -----
// One motor lane of the cyclic mixer: cosine lookup, shared multiplier,
// accumulate, round, limit and clamp. Depends on cmm_pkg.
module cmm_lane #(
  parameter int unsigned COS_TABLE_BITS = cmm_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmm_pkg::cmm_lane_ctrl_t ctrl_i,
  input  logic signed [15:0]     roll_i,
  input  logic signed [15:0]     pitch_i,
  input  logic signed [15:0]     yaw_i,
  input  logic [14:0]            roll_gain_i,
  input  logic [14:0]            pitch_gain_i,
  input  logic [14:0]            yaw_gain_i,
  input  logic [13:0]            cyclic_limit_i,
  input  logic [14:0]            collective_i,
  input  logic [15:0]            angle_i,
  input  logic [15:0]            roll_phase_i,
  input  logic [15:0]            pitch_phase_i,
  input  logic signed [15:0]     yaw_bias_i,
  output logic [14:0]            drive_o,
  output cmm_pkg::cmm_lane_stat_t stat_o
);
  import cmm_pkg::*;

  localparam int unsigned RemW     = COS_TABLE_BITS - 2;
  localparam int unsigned AddrW    = COS_TABLE_BITS - 1;
  localparam int unsigned RomDepth = (1 << RemW) + 1;
  localparam logic [AddrW-1:0] QuarterTurn = AddrW'(1) << RemW;

  logic [14:0] cos_rom [RomDepth];

  // Quarter-wave cosine table, constant
  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    assign cos_rom[k] = cmm_cos_entry(k, COS_TABLE_BITS);
  end

  // Fold a quantized angle into the first quadrant
  function automatic logic [AddrW-1:0] cos_addr(input logic [COS_TABLE_BITS-1:0] idx);
    logic [AddrW-1:0] rem;
    rem = {1'b0, idx[RemW-1:0]};
    return idx[COS_TABLE_BITS-2] ? AddrW'(QuarterTurn - rem) : rem;
  endfunction

  logic [15:0]               roll_diff, pitch_diff;
  logic [COS_TABLE_BITS-1:0] roll_idx, pitch_idx;
  logic [AddrW-1:0]          roll_addr, pitch_addr;
  logic signed [15:0]        roll_cos, pitch_cos;

  // Look up both cosines, sign from the quadrant
  always_comb begin
    roll_diff  = angle_i - roll_phase_i;
    pitch_diff = angle_i - pitch_phase_i;
    roll_idx   = roll_diff[15 -: COS_TABLE_BITS];
    pitch_idx  = pitch_diff[15 -: COS_TABLE_BITS];
    roll_addr  = cos_addr(roll_idx);
    pitch_addr = cos_addr(pitch_idx);
    roll_cos   = signed'({1'b0, cos_rom[roll_addr]});
    pitch_cos  = signed'({1'b0, cos_rom[pitch_addr]});
    if (roll_idx[COS_TABLE_BITS-1] ^ roll_idx[COS_TABLE_BITS-2]) roll_cos = -roll_cos;
    if (pitch_idx[COS_TABLE_BITS-1] ^ pitch_idx[COS_TABLE_BITS-2]) pitch_cos = -pitch_cos;
  end

  logic signed [15:0] cos_roll_q, cos_pitch_q;
  logic signed [46:0] prod_q, acc_q;
  logic signed [14:0] cyc_q;
  logic [14:0]        drive_q;
  logic               hi_q, lo_q;

  logic signed [30:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [46:0] mul_p;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.op)
      OP_ROLL_GAIN: begin
        mul_a = 31'(roll_i);
        mul_b = signed'({1'b0, roll_gain_i});
      end
      OP_ROLL_COS: begin
        mul_a = prod_q[30:0];
        mul_b = cos_roll_q;
      end
      OP_PITCH_GAIN: begin
        mul_a = 31'(pitch_i);
        mul_b = signed'({1'b0, pitch_gain_i});
      end
      OP_PITCH_COS: begin
        mul_a = prod_q[30:0];
        mul_b = cos_pitch_q;
      end
      OP_YAW_GAIN: begin
        mul_a = 31'(yaw_i);
        mul_b = signed'({1'b0, yaw_gain_i});
      end
      OP_YAW_BIAS: begin
        mul_a = prod_q[30:0];
        mul_b = yaw_bias_i;
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [46:0] biased;
  logic signed [18:0] rounded, lim_pos;
  logic signed [16:0] sum;

  // Round Q42 to Q14 with ties up, then limit; add collective and clamp
  always_comb begin
    biased  = acc_q + 47'sd134217728;
    rounded = biased[46:28];
    lim_pos = signed'({5'b0, cyclic_limit_i});
    sum     = signed'({2'b0, collective_i}) + {{2{cyc_q[14]}}, cyc_q};
  end

  // Advance the lane datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      case (ctrl_i.op) inside
        OP_ROLL_GAIN: begin
          cos_roll_q  <= roll_cos;
          cos_pitch_q <= pitch_cos;
          prod_q      <= mul_p;
        end
        OP_ROLL_COS, OP_PITCH_COS, OP_YAW_BIAS: prod_q <= mul_p;
        OP_PITCH_GAIN: begin
          acc_q  <= prod_q;
          prod_q <= mul_p;
        end
        OP_YAW_GAIN: begin
          acc_q  <= acc_q + prod_q;
          prod_q <= mul_p;
        end
        OP_YAW_ACC: acc_q <= acc_q + prod_q;
        OP_ROUND: begin
          if (rounded > lim_pos)       cyc_q <= 15'(lim_pos);
          else if (rounded < -lim_pos) cyc_q <= 15'(-lim_pos);
          else                         cyc_q <= rounded[14:0];
        end
        OP_CLAMP: begin
          if (sum < 0)                            drive_q <= '0;
          else if (sum > signed'({2'b0, Q14_ONE})) drive_q <= Q14_ONE;
          else                                    drive_q <= sum[14:0];
        end
        default: ;
      endcase
    end
  end

  // Saturation flags follow the clamped drive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= 1'b0;
      lo_q <= 1'b0;
    end else if (ctrl_i.en && ctrl_i.op == OP_CLAMP) begin
      if (sum < 0) begin
        hi_q <= 1'b0;
        lo_q <= 1'b1;
      end else if (sum > signed'({2'b0, Q14_ONE})) begin
        hi_q <= 1'b1;
        lo_q <= 1'b0;
      end else begin
        hi_q <= sum[14:0] >= HIGH_THRESH;
        lo_q <= sum[14:0] <= LOW_THRESH;
      end
    end
  end

  assign drive_o   = drive_q;
  assign stat_o.hi = hi_q;
  assign stat_o.lo = lo_q;

endmodule

// ----- hdl/cyclic_modulated_motor_mixer.sv -----
// Top level of the three-rotor cyclic mixer: input capture, configuration
// registers, step sequencer, three cmm_lane instances and the merge stage.
// Depends on cmm_pkg and cmm_lane.

// Each accepted tick produces one result. A new tick is taken only once the
// previous one has been loaded into the output register, so the block works
// on one tick at a time. The single multiplier inside each motor lane
// performs the six gain and cosine products one after another before
// rounding, limiting and clamping. All three motors run in parallel lanes;
// the merge stage then applies the spool mode and encoder health and updates
// the held saturation flags. The finished result sits in an output register,
// so the next tick can be accepted while it waits. Configuration writes are
// always ready and must only occur while idle.
module cyclic_modulated_motor_mixer #(
  parameter int unsigned COS_TABLE_BITS = cmm_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             roll_cmd_i,
  input  logic signed [15:0]             pitch_cmd_i,
  input  logic signed [15:0]             yaw_cmd_i,
  input  logic [14:0]                    throttle_cmd_i,
  input  logic [15:0]                    angle_one_i,
  input  logic [15:0]                    angle_two_i,
  input  logic [15:0]                    angle_three_i,
  input  logic [2:0]                     health_mask_i,
  input  logic [1:0]                     spool_mode_i,
  input  logic [14:0]                    idle_level_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [14:0]                    drive_one_o,
  output logic [14:0]                    drive_two_o,
  output logic [14:0]                    drive_three_o,
  output logic                           attitude_limited_o,
  output logic                           throttle_low_limited_o,
  output logic                           throttle_high_limited_o
);
  import cmm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_MERGE = 3'b100
  } cmm_state_e;

  // Limit a command to plus or minus one
  function automatic logic signed [15:0] clamp_cmd(input logic signed [15:0] x);
    if (x > 16'sd16384)  return 16'sd16384;
    if (x < -16'sd16384) return -16'sd16384;
    return x;
  endfunction

  // ---------------- configuration ----------------
  logic [15:0] collective_gain_q;
  logic [14:0] roll_gain_q, pitch_gain_q, yaw_gain_q;
  logic [13:0] cyclic_limit_q;
  logic [47:0] roll_phase_q, pitch_phase_q, yaw_bias_q;

  assign cfg_ready_o = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collective_gain_q <= RST_COLLECTIVE_GAIN;
      roll_gain_q       <= RST_ROLL_GAIN;
      pitch_gain_q      <= RST_PITCH_GAIN;
      yaw_gain_q        <= RST_YAW_GAIN;
      cyclic_limit_q    <= RST_CYCLIC_LIMIT;
      roll_phase_q      <= RST_ROLL_PHASE;
      pitch_phase_q     <= RST_PITCH_PHASE;
      yaw_bias_q        <= RST_YAW_BIAS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COLLECTIVE_GAIN: collective_gain_q <= cfg_data_i[15:0];
        REG_ROLL_GAIN:       roll_gain_q       <= cfg_data_i[14:0];
        REG_PITCH_GAIN:      pitch_gain_q      <= cfg_data_i[14:0];
        REG_YAW_GAIN:        yaw_gain_q        <= cfg_data_i[14:0];
        REG_CYCLIC_LIMIT:    cyclic_limit_q    <= cfg_data_i[13:0];
        REG_ROLL_PHASE:      roll_phase_q      <= cfg_data_i;
        REG_PITCH_PHASE:     pitch_phase_q     <= cfg_data_i;
        REG_YAW_BIAS:        yaw_bias_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  cmm_state_e state_q, state_d;
  cmm_op_e    op_q, op_d;
  logic       in_xfer, out_free, out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign out_load   = (state_q == ST_MERGE) && out_free;

  // Step through the lane sequence, then hold for a free output slot
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RUN;
          op_d    = OP_ROLL_GAIN;
        end
      end
      ST_RUN: begin
        if (op_q == OP_CLAMP) begin
          state_d = ST_MERGE;
          op_d    = OP_NONE;
        end else begin
          op_d = cmm_op_e'(4'(op_q + 4'd1));
        end
      end
      ST_MERGE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        op_d    = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // ---------------- input capture ----------------
  logic signed [15:0] roll_q, pitch_q, yaw_q;
  logic [14:0]        throttle_q, idle_q;
  logic [15:0]        angle_q [MOTOR_COUNT];
  logic [2:0]         health_q;
  logic [1:0]         mode_q;

  // Hold the transferred item, commands already clamped
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      roll_q     <= clamp_cmd(roll_cmd_i);
      pitch_q    <= clamp_cmd(pitch_cmd_i);
      yaw_q      <= clamp_cmd(yaw_cmd_i);
      throttle_q <= throttle_cmd_i;
      angle_q[0] <= angle_one_i;
      angle_q[1] <= angle_two_i;
      angle_q[2] <= angle_three_i;
      health_q   <= health_mask_i;
      mode_q     <= spool_mode_i;
      idle_q     <= idle_level_i;
    end
  end

  // ---------------- collective ----------------
  logic [30:0] col_prod_q;
  logic [16:0] col_round;
  logic [14:0] col_q;

  assign col_round = 17'((32'(col_prod_q) + 32'd8192) >> 14);

  // Throttle times gain, rounded and clamped to one
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && op_q == OP_ROLL_GAIN) begin
      col_prod_q <= throttle_q * collective_gain_q;
    end
    if (state_q == ST_RUN && op_q == OP_ROLL_COS) begin
      col_q <= (col_round > 17'(Q14_ONE)) ? Q14_ONE : col_round[14:0];
    end
  end

  // ---------------- lanes ----------------
  cmm_lane_ctrl_t lane_ctrl;
  logic [14:0]    lane_drive [MOTOR_COUNT];
  cmm_lane_stat_t lane_stat  [MOTOR_COUNT];

  assign lane_ctrl.en = (state_q == ST_RUN);
  assign lane_ctrl.op = op_q;

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    cmm_lane #(
      .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (lane_ctrl),
      .roll_i         (roll_q),
      .pitch_i        (pitch_q),
      .yaw_i          (yaw_q),
      .roll_gain_i    (roll_gain_q),
      .pitch_gain_i   (pitch_gain_q),
      .yaw_gain_i     (yaw_gain_q),
      .cyclic_limit_i (cyclic_limit_q),
      .collective_i   (col_q),
      .angle_i        (angle_q[m]),
      .roll_phase_i   (roll_phase_q[16*m +: 16]),
      .pitch_phase_i  (pitch_phase_q[16*m +: 16]),
      .yaw_bias_i     (signed'(yaw_bias_q[16*m +: 16])),
      .drive_o        (lane_drive[m]),
      .stat_o         (lane_stat[m])
    );
  end

  // ---------------- merge ----------------
  logic        any_hi, any_lo;
  logic [14:0] idle_clamped;
  logic [14:0] merge_drive [MOTOR_COUNT];
  logic        held_low_q, held_high_q, low_d, high_d;

  // Combine lane flags and apply spool mode and encoder health
  always_comb begin
    any_hi = 1'b0;
    any_lo = 1'b0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      any_hi = any_hi | lane_stat[m].hi;
      any_lo = any_lo | lane_stat[m].lo;
    end
    idle_clamped = (idle_q > Q14_ONE) ? Q14_ONE : idle_q;
    low_d  = held_low_q;
    high_d = held_high_q;
    for (int m = 0; m < MOTOR_COUNT; m++) merge_drive[m] = '0;
    unique case (mode_q)
      SPOOL_SHUTDOWN: ;
      SPOOL_GROUND: begin
        for (int m = 0; m < MOTOR_COUNT; m++) merge_drive[m] = idle_clamped;
      end
      default: begin
        if (health_q != 3'b111) begin
          low_d  = 1'b1;
          high_d = 1'b0;
        end else begin
          for (int m = 0; m < MOTOR_COUNT; m++) merge_drive[m] = lane_drive[m];
          low_d  = any_lo;
          high_d = any_hi;
        end
      end
    endcase
  end

  // Held saturation flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_low_q  <= 1'b0;
      held_high_q <= 1'b0;
    end else if (out_load) begin
      held_low_q  <= low_d;
      held_high_q <= high_d;
    end
  end

  // ---------------- output register ----------------
  logic        out_valid_q;
  logic [14:0] drive_q [MOTOR_COUNT];
  logic        flag_low_q, flag_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int m = 0; m < MOTOR_COUNT; m++) drive_q[m] <= merge_drive[m];
      flag_low_q  <= low_d;
      flag_high_q <= high_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign drive_one_o             = drive_q[0];
  assign drive_two_o             = drive_q[1];
  assign drive_three_o           = drive_q[2];
  assign attitude_limited_o      = flag_low_q | flag_high_q;
  assign throttle_low_limited_o  = flag_low_q;
  assign throttle_high_limited_o = flag_high_q;

endmodule

// ----- bench/tb_cyclic_modulated_motor_mixer.sv -----
// Self-checking bench for cyclic_modulated_motor_mixer: drives control ticks and register
// writes, predicts the three drive values and saturation flags, checks every result.
// Depends on cmm_pkg and the mixer RTL.
module tb_cyclic_modulated_motor_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import cmm_pkg::*;

  localparam int unsigned COS_BITS      = COS_TABLE_BITS_DEF;
  localparam int unsigned COS_SHIFT     = 16 - COS_BITS;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASE_ITEMS   = 240;
  localparam logic [2:0]  ALL_HEALTHY   = 3'b111;
  localparam logic [1:0]  SPOOL_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  typedef struct packed {
    logic [15:0]      roll;
    logic [15:0]      pitch;
    logic [15:0]      yaw;
    logic [14:0]      throttle;
    logic [2:0][15:0] angle;
    logic [2:0]       health;
    logic [1:0]       spool;
    logic [14:0]      idle;
  } tick_t;

  typedef struct packed {
    logic [2:0][14:0] drive;
    logic             attitude;
    logic             low_lim;
    logic             high_lim;
  } drive_set_t;

  typedef struct packed {
    logic [15:0] collective_gain;
    logic [14:0] roll_gain;
    logic [14:0] pitch_gain;
    logic [14:0] yaw_gain;
    logic [13:0] cyclic_limit;
    logic [47:0] roll_phase;
    logic [47:0] pitch_phase;
    logic [47:0] yaw_bias;
  } mixer_regs_t;

  // DUT connections, all inputs known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [15:0]    roll_cmd_i     = '0;
  logic signed [15:0]    pitch_cmd_i    = '0;
  logic signed [15:0]    yaw_cmd_i      = '0;
  logic [14:0]           throttle_cmd_i = '0;
  logic [15:0]           angle_one_i    = '0;
  logic [15:0]           angle_two_i    = '0;
  logic [15:0]           angle_three_i  = '0;
  logic [2:0]            health_mask_i  = '0;
  logic [1:0]            spool_mode_i   = '0;
  logic [14:0]           idle_level_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [14:0]           drive_one_o;
  logic [14:0]           drive_two_o;
  logic [14:0]           drive_three_o;
  logic                  attitude_limited_o;
  logic                  throttle_low_limited_o;
  logic                  throttle_high_limited_o;

  // Predictor state and scoreboard
  mixer_regs_t  regs;
  logic         held_lo = 1'b0;
  logic         held_hi = 1'b0;
  drive_set_t   expected_drives[$];
  int unsigned  mismatch_count   = 0;
  int unsigned  src_gap_max      = 15;
  int unsigned  snk_gap_max      = 15;
  int unsigned  sink_hold_cycles = 0;

  cyclic_modulated_motor_mixer #(
    .COS_TABLE_BITS(COS_BITS)
  ) u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .roll_cmd_i             (roll_cmd_i),
    .pitch_cmd_i            (pitch_cmd_i),
    .yaw_cmd_i              (yaw_cmd_i),
    .throttle_cmd_i         (throttle_cmd_i),
    .angle_one_i            (angle_one_i),
    .angle_two_i            (angle_two_i),
    .angle_three_i          (angle_three_i),
    .health_mask_i          (health_mask_i),
    .spool_mode_i           (spool_mode_i),
    .idle_level_i           (idle_level_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .drive_one_o            (drive_one_o),
    .drive_two_o            (drive_two_o),
    .drive_three_o          (drive_three_o),
    .attitude_limited_o     (attitude_limited_o),
    .throttle_low_limited_o (throttle_low_limited_o),
    .throttle_high_limited_o(throttle_high_limited_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Cosine of a quantized turn fraction in Q1.14, Taylor series in Q30
  function automatic longint turn_cos(input logic [15:0] diff);
    logic [15:0] q;
    longint      arg;
    longint      x;
    longint      x2;
    longint      t;
    longint      v;
    int          k;
    q   = (diff >> COS_SHIFT) << COS_SHIFT;
    arg = q[14] ? (64'sd16384 - longint'(q[13:0])) : longint'(q[13:0]);
    x   = (arg * TWO_PI_Q30) >>> 16;
    x2  = (x * x) >>> 30;
    t   = Q30_ONE;
    // nested form: divisors 12*11, 10*9, ... 2*1
    for (k = 6; k >= 1; k--) begin
      t = Q30_ONE - ((x2 * t) / Q30_ONE) / longint'(2 * k * (2 * k - 1));
    end
    if (t < 0) t = 0;
    v = (t + 32768) >>> 16;
    if (v > 16384) v = 16384;
    return (q[15] ^ q[14]) ? -v : v;
  endfunction

  function automatic longint cmd_limit(input logic [15:0] c);
    longint v;
    v = longint'($signed(c));
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  // Compute the result of one tick and advance the held flags
  function automatic drive_set_t predict_drives(input tick_t t);
    drive_set_t r;
    longint     rc;
    longint     pc;
    longint     yc;
    longint     col;
    longint     lim;
    longint     sum;
    longint     cyc;
    logic [15:0] rdiff;
    logic [15:0] pdiff;
    logic       hi;
    logic       lo;
    int         m;
    r = '0;
    if (t.spool == SPOOL_SHUTDOWN) begin
      // drives stay zero, flags hold
    end else if (t.spool == SPOOL_GROUND) begin
      for (m = 0; m < 3; m++) r.drive[m] = (t.idle > Q14_ONE) ? Q14_ONE : t.idle;
    end else if (t.health != ALL_HEALTHY) begin
      held_lo = 1'b1;
      held_hi = 1'b0;
    end else begin
      rc  = cmd_limit(t.roll);
      pc  = cmd_limit(t.pitch);
      yc  = cmd_limit(t.yaw);
      col = (longint'(t.throttle) * longint'(regs.collective_gain) + 8192) >>> 14;
      if (col > 16384) col = 16384;
      lim = longint'(regs.cyclic_limit);
      hi  = 1'b0;
      lo  = 1'b0;
      for (m = 0; m < 3; m++) begin
        rdiff = t.angle[m] - regs.roll_phase[16*m +: 16];
        pdiff = t.angle[m] - regs.pitch_phase[16*m +: 16];
        sum = rc * longint'(regs.roll_gain) * turn_cos(rdiff)
            + pc * longint'(regs.pitch_gain) * turn_cos(pdiff)
            + yc * longint'(regs.yaw_gain) * longint'($signed(regs.yaw_bias[16*m +: 16]));
        // round Q42 to Q14, ties toward plus infinity
        cyc = (sum + 64'sd134217728) >>> 28;
        if (cyc > lim) cyc = lim;
        if (cyc < -lim) cyc = -lim;
        sum = col + cyc;
        if (sum < 0) sum = 0;
        if (sum > 16384) sum = 16384;
        r.drive[m] = sum[14:0];
        if (sum >= longint'(HIGH_THRESH)) hi = 1'b1;
        if (sum <= longint'(LOW_THRESH)) lo = 1'b1;
      end
      held_lo = lo;
      held_hi = hi;
    end
    r.low_lim  = held_lo;
    r.high_lim = held_hi;
    r.attitude = held_lo | held_hi;
    return r;
  endfunction

  // Mirror a register write into the predictor; unknown indexes are dropped
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COLLECTIVE_GAIN: regs.collective_gain = data[15:0];
      REG_ROLL_GAIN:       regs.roll_gain       = data[14:0];
      REG_PITCH_GAIN:      regs.pitch_gain      = data[14:0];
      REG_YAW_GAIN:        regs.yaw_gain        = data[14:0];
      REG_CYCLIC_LIMIT:    regs.cyclic_limit    = data[13:0];
      REG_ROLL_PHASE:      regs.roll_phase      = data;
      REG_PITCH_PHASE:     regs.pitch_phase     = data;
      REG_YAW_BIAS:        regs.yaw_bias        = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic mixer_regs_t reset_setup();
    mixer_regs_t s;
    s.collective_gain = RST_COLLECTIVE_GAIN;
    s.roll_gain       = RST_ROLL_GAIN;
    s.pitch_gain      = RST_PITCH_GAIN;
    s.yaw_gain        = RST_YAW_GAIN;
    s.cyclic_limit    = RST_CYCLIC_LIMIT;
    s.roll_phase      = RST_ROLL_PHASE;
    s.pitch_phase     = RST_PITCH_PHASE;
    s.yaw_bias        = RST_YAW_BIAS;
    return s;
  endfunction

  function automatic mixer_regs_t random_setup();
    mixer_regs_t s;
    s.collective_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 32768));
    s.roll_gain    = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    s.pitch_gain   = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    s.yaw_gain     = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    s.cyclic_limit = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 8192));
    s.roll_phase   = 48'({$urandom, $urandom});
    s.pitch_phase  = 48'({$urandom, $urandom});
    s.yaw_bias     = 48'({$urandom, $urandom});
    return s;
  endfunction

  function automatic logic [15:0] random_cmd();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [14:0] random_level();
    if ($urandom_range(0, 7) == 0) return 15'($urandom);
    return 15'($urandom_range(0, 16384));
  endfunction

  // Mostly healthy active mixing; the rest covers the other spool states and bad encoders
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      t.spool = SPOOL_SHUTDOWN;
    else if (pick < 20) t.spool = SPOOL_GROUND;
    else if (pick < 26) t.spool = SPOOL_SPARE;
    else                t.spool = SPOOL_ACTIVE;
    t.health   = ($urandom_range(0, 9) == 0) ? 3'($urandom) : ALL_HEALTHY;
    t.roll     = random_cmd();
    t.pitch    = random_cmd();
    t.yaw      = random_cmd();
    t.throttle = random_level();
    t.angle[0] = 16'($urandom);
    t.angle[1] = 16'($urandom);
    t.angle[2] = 16'($urandom);
    t.idle     = random_level();
    return t;
  endfunction

  function automatic tick_t make_tick(input logic [1:0] spool, input logic [2:0] health,
                                      input logic [15:0] roll, input logic [15:0] pitch,
                                      input logic [15:0] yaw, input logic [14:0] throttle,
                                      input logic [15:0] a1, input logic [15:0] a2,
                                      input logic [15:0] a3, input logic [14:0] idle);
    tick_t t;
    t.spool    = spool;
    t.health   = health;
    t.roll     = roll;
    t.pitch    = pitch;
    t.yaw      = yaw;
    t.throttle = throttle;
    t.angle[0] = a1;
    t.angle[1] = a2;
    t.angle[2] = a3;
    t.idle     = idle;
    return t;
  endfunction

  // Offer one tick after a random gap; valid stays high for a back-to-back follower
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    roll_cmd_i     <= t.roll;
    pitch_cmd_i    <= t.pitch;
    yaw_cmd_i      <= t.yaw;
    throttle_cmd_i <= t.throttle;
    angle_one_i    <= t.angle[0];
    angle_two_i    <= t.angle[1];
    angle_three_i  <= t.angle[2];
    health_mask_i  <= t.health;
    spool_mode_i   <= t.spool;
    idle_level_i   <= t.idle;
    do @(posedge clk_i); while (in_stall_o);
    expected_drives.push_back(predict_drives(t));
  endtask

  // Drop valid and wait until every expected result has been transferred
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, data);
  endtask

  // Write all eight registers; optionally fill the bits above each width with junk
  task automatic load_setup(input mixer_regs_t s, input bit junk_upper);
    logic [47:0] pad;
    pad = junk_upper ? 48'({$urandom, $urandom}) : '0;
    write_reg(REG_COLLECTIVE_GAIN, {pad[47:16], s.collective_gain});
    write_reg(REG_ROLL_GAIN,       {pad[47:15], s.roll_gain});
    write_reg(REG_PITCH_GAIN,      {pad[47:15], s.pitch_gain});
    write_reg(REG_YAW_GAIN,        {pad[47:15], s.yaw_gain});
    write_reg(REG_CYCLIC_LIMIT,    {pad[47:14], s.cyclic_limit});
    write_reg(REG_ROLL_PHASE,      s.roll_phase);
    write_reg(REG_PITCH_PHASE,     s.pitch_phase);
    write_reg(REG_YAW_BIAS,        s.yaw_bias);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Spool states, encoder health, held flags and command extremes at reset settings
  task automatic test_spool_modes();
    send_tick(make_tick(SPOOL_SHUTDOWN, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd8000,
                        16'd0, 16'd0, 16'd0, 15'd5000));
    send_tick(make_tick(SPOOL_GROUND, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd0,
                        16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(make_tick(SPOOL_GROUND, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd0,
                        16'd0, 16'd0, 16'd0, 15'd16384));
    send_tick(make_tick(SPOOL_GROUND, 3'b000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd0,
                        16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'd16384, -16'sd16384, 16'd16384,
                        15'd16384, 16'd0, 16'd21845, 16'd43690, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'h8000, 16'h7FFF, 16'h8000, 15'd8192,
                        16'hFFFF, 16'd16384, 16'd32768, 15'd0));
    // flags must hold through shutdown and ground idle
    send_tick(make_tick(SPOOL_SHUTDOWN, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd0,
                        16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(make_tick(SPOOL_GROUND, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'd0,
                        16'd0, 16'd0, 16'd0, 15'd9000));
    send_tick(make_tick(SPOOL_ACTIVE, 3'b110, 16'd4000, 16'd4000, 16'd4000, 15'd16384,
                        16'd100, 16'd200, 16'd300, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, 3'b000, 16'd0, 16'd0, 16'd0, 15'd8000,
                        16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(make_tick(SPOOL_SPARE, ALL_HEALTHY, 16'd8000, -16'sd8000, 16'd2000, 15'd9000,
                        16'd5000, 16'd30000, 16'd60000, 15'd0));
    send_tick(make_tick(SPOOL_SPARE, 3'b011, 16'd0, 16'd0, 16'd0, 15'd9000,
                        16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, -16'sd16384, 16'd16384, -16'sd16384,
                        15'h7FFF, 16'd49152, 16'd16384, 16'd0, 15'd0));
    drain_results();
  endtask

  // All registers at zero, then at all ones, then a write to an unused index
  task automatic test_register_extremes();
    mixer_regs_t s;
    s = '0;
    load_setup(s, 1'b0);
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'd16384, 16'd16384, 16'd16384,
                        15'd16384, 16'd0, 16'd0, 16'd0, 15'd0));
    send_tick(random_tick());
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0));
    drain_results();
    s = '1;
    load_setup(s, 1'b0);
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'd16384, 16'd16384, 16'd16384,
                        15'd16384, 16'd0, 16'd21845, 16'd43690, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, -16'sd16384, -16'sd16384, -16'sd16384,
                        15'd1, 16'd32768, 16'd32768, 16'd32768, 15'd0));
    send_tick(make_tick(SPOOL_ACTIVE, ALL_HEALTHY, 16'd0, 16'd0, 16'd0, 15'h7FFF,
                        16'd0, 16'd0, 16'd0, 15'd0));
    drain_results();
    write_reg(REG_SPARE, '1);
    cfg_valid_i <= 1'b0;
    send_tick(random_tick());
    send_tick(random_tick());
    drain_results();
  endtask

  // Hold the output for a long stretch while ticks keep coming, so the input backs up
  task automatic test_backpressure();
    int n;
    src_gap_max      = 0;
    snk_gap_max      = 0;
    sink_hold_cycles = 200;
    for (n = 0; n < 16; n++) send_tick(random_tick());
    drain_results();
    src_gap_max = 15;
    snk_gap_max = 15;
  endtask

  // Random ticks over several register settings with bursts of idling and none
  task automatic test_random_mixing();
    mixer_regs_t s;
    int          phase;
    int          n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: s = reset_setup();
        1: begin
          s.collective_gain = 16'd32768;
          s.roll_gain       = 15'd16384;
          s.pitch_gain      = 15'd16384;
          s.yaw_gain        = 15'd16384;
          s.cyclic_limit    = 14'd8192;
          s.roll_phase      = {16'd43690, 16'd21845, 16'd0};
          s.pitch_phase     = {16'd60074, 16'd38229, 16'd16384};
          s.yaw_bias        = {16'h4000, 16'hC000, 16'h0000};
        end
        default: s = random_setup();
      endcase
      load_setup(s, phase >= 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
          snk_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
        end
        send_tick(random_tick());
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random output stalls, plus a long hold when a test requests one
  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles != 0) begin
        pause            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        pause = $urandom_range(0, snk_gap_max);
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic compare_field(input string label, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each transferred result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    drive_set_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: result transferred with no expectation pending", $time);
        mismatch_count++;
      end else begin
        want = expected_drives.pop_front();
        compare_field("drive_one", want.drive[0], drive_one_o);
        compare_field("drive_two", want.drive[1], drive_two_o);
        compare_field("drive_three", want.drive[2], drive_three_o);
        compare_field("attitude_limited", want.attitude, attitude_limited_o);
        compare_field("throttle_low_limited", want.low_lim, throttle_low_limited_o);
        compare_field("throttle_high_limited", want.high_lim, throttle_high_limited_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence and watchdog
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    regs    = reset_setup();
    held_lo = 1'b0;
    held_hi = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_spool_modes();
    test_register_extremes();
    test_backpressure();
    test_random_mixing();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cmm_pkg.sv
hdl/cmm_lane.sv
hdl/cyclic_modulated_motor_mixer.sv
bench/tb_cyclic_modulated_motor_mixer.sv
